>>> src/block_bitmap_allocator_top_defines.svh
// Assertion macros shared by the bitmap allocator RTL.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// A property that must hold in the same cycle, checked outside reset.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A property whose consequent must hold in the cycle after the antecedent, checked outside reset.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bba_pkg.sv
// Package with the shared constants and helpers of the bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int unsigned NUM_WORDS_DEF = 128;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BLK_W         = 12;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned POS_W         = 5;

  localparam logic [WORD_W-1:0] FULL_WORD = 32'hffff_ffff;
  localparam logic [WORD_W-1:0] TOP_BIT   = 32'h8000_0000;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Position of the first clear bit counted from the top bit; the word must not be full.
  function automatic logic [POS_W-1:0] first_zero(input logic [WORD_W-1:0] word);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[WORD_W-1-i]) begin
        pos = POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

>>> src/block_bitmap_allocator_top.sv
// Top level of the bitmap free-block allocator.
//
//  Channel | Direction | tdata (low bit up)                   | tuser
//  in_     | slave     | block_number[11:0], 4'b0             | mode
//  out_    | master    | granted_block[11:0], status[1:0], 2'b0 | none
//
// After reset a clearing pass writes every bitmap word with in_tready low.
// A free beat reads the word, writes it back, then loads the result register.
// An allocation scans one word per cycle from word 0 through the single read port of the
// bitmap RAM. A result waits in the output register while the next beat is accepted;
// a second result waits until that register is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "block_bitmap_allocator_top_defines.svh"
module block_bitmap_allocator_top #(
  parameter int unsigned NUM_WORDS = bba_pkg::NUM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // block_number[11:0], zero pad
  input  wire logic        in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata   // granted_block[11:0], status[13:12], zero pad
);
  import bba_pkg::*;

  localparam int unsigned WA         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned NUM_BLOCKS = NUM_WORDS * WORD_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ALLOC_WR,
    S_FREE_WR,
    S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [WA:0]         cnt_r, cnt_nxt;
  logic                data_vld_r, data_vld_nxt;
  logic [WA-1:0]       data_idx_r, data_idx_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [WA-1:0]       widx_r, widx_nxt;
  logic [POS_W-1:0]    bit_r, bit_nxt;
  logic [BLK_W-1:0]    res_grant_r, res_grant_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [15:0]         out_tdata_r, out_tdata_nxt;

  logic                ram_we, ram_re;
  logic [WA-1:0]       ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic [BLK_W-1:0]    in_blk;
  logic                in_mode, in_acc, blk_in_range, out_load;
  logic [POS_W-1:0]    alloc_pos;

  assign in_blk       = in_tdata[BLK_W-1:0];
  assign in_mode      = in_tuser;
  assign in_acc       = in_tvalid && in_tready;
  assign blk_in_range = {20'd0, in_blk} < 32'(NUM_BLOCKS);
  assign alloc_pos    = first_zero(word_r);

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS),
    .AW    (WA)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    data_vld_nxt   = data_vld_r;
    data_idx_nxt   = data_idx_r;
    word_nxt       = word_r;
    widx_nxt       = widx_r;
    bit_nxt        = bit_r;
    res_grant_nxt  = res_grant_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_load       = 1'b0;
    in_tready      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = widx_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = cnt_r[WA-1:0];

    unique case (state_r)
      S_CLEAR: begin
        // Word 0 keeps block 0 reserved; every other word starts free.
        ram_we    = 1'b1;
        ram_waddr = cnt_r[WA-1:0];
        ram_wdata = (cnt_r == '0) ? TOP_BIT : '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[WA-1:0] == WA'(NUM_WORDS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (in_mode == MODE_FREE) begin
            if (blk_in_range) begin
              ram_re    = 1'b1;
              ram_raddr = WA'(in_blk >> 5);
              widx_nxt  = WA'(in_blk >> 5);
              bit_nxt   = in_blk[POS_W-1:0];
              state_nxt = S_FREE_WR;
            end else begin
              res_grant_nxt  = '0;
              res_status_nxt = ST_RANGE;
              state_nxt      = S_RESP;
            end
          end else begin
            cnt_nxt      = '0;
            data_vld_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Reads are issued back to back; the word read in the previous cycle is checked here.
        if (cnt_r < (WA+1)'(NUM_WORDS)) begin
          ram_re       = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          data_vld_nxt = 1'b1;
          data_idx_nxt = cnt_r[WA-1:0];
        end else begin
          data_vld_nxt = 1'b0;
        end
        if (data_vld_r) begin
          if (ram_rdata != FULL_WORD) begin
            word_nxt     = ram_rdata;
            widx_nxt     = data_idx_r;
            data_vld_nxt = 1'b0;
            state_nxt    = S_ALLOC_WR;
          end else if (data_idx_r == WA'(NUM_WORDS - 1)) begin
            res_grant_nxt  = '0;
            res_status_nxt = ST_FULL;
            data_vld_nxt   = 1'b0;
            state_nxt      = S_RESP;
          end
        end
      end
      S_ALLOC_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = word_r | (TOP_BIT >> alloc_pos);
        res_grant_nxt  = BLK_W'({widx_r, alloc_pos});
        res_status_nxt = ST_OK;
        state_nxt      = S_RESP;
      end
      S_FREE_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata & ~(TOP_BIT >> bit_r);
        res_grant_nxt  = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, res_status_r, res_grant_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      data_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      data_vld_r   <= data_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    data_idx_r   <= data_idx_nxt;
    word_r       <= word_nxt;
    widx_r       <= widx_nxt;
    bit_r        <= bit_nxt;
    res_grant_r  <= res_grant_nxt;
    res_status_r <= res_status_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `BBA_ASSERT_NOW(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr, "bitmap read and write hit the same word")
  `BBA_ASSERT_NOW(a_load_only_when_free, out_load, !out_tvalid_r || out_tready, "result register overwritten before it was taken")
  `BBA_ASSERT_NEXT(a_one_beat_at_a_time, in_tvalid && in_tready, !in_tready, "second beat accepted while one is in progress")

endmodule
`default_nettype wire

>>> src/bba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_block_bitmap_allocator_top.sv
// Self-checking testbench for the bitmap free-block allocator top level.
`timescale 1ns / 1ps
module tb_block_bitmap_allocator_top;
  import bba_pkg::*;

  localparam int unsigned MAP_WORDS   = NUM_WORDS_DEF;
  localparam int unsigned MAP_BLOCKS  = MAP_WORDS * WORD_W;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = MAP_WORDS + 20;

  typedef struct packed {
    logic [BLK_W-1:0]    grant;
    logic [STATUS_W-1:0] status;
  } grant_result_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // block_number[11:0], zero pad
  logic        in_tuser   = 1'b0; // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // granted_block[11:0], status[13:12], zero pad

  logic [WORD_W-1:0] usage_map [MAP_WORDS];
  grant_result_t     pending_results [$];
  logic [BLK_W-1:0]  held_blocks [$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles = 0;

  block_bitmap_allocator_top #(
    .NUM_WORDS (MAP_WORDS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the local copy of the bitmap and returns the result it gives.
  function automatic grant_result_t predict_grant(input logic mode, input logic [BLK_W-1:0] blk);
    grant_result_t res;
    logic          found;
    res.grant  = '0;
    res.status = ST_OK;
    found      = 1'b0;
    if (mode == MODE_ALLOC) begin
      res.status = ST_FULL;
      for (int w = 0; w < MAP_WORDS && !found; w++) begin
        for (int p = 0; p < WORD_W && !found; p++) begin
          if (!usage_map[w][WORD_W-1-p]) begin
            usage_map[w][WORD_W-1-p] = 1'b1;
            res.grant  = BLK_W'(w * WORD_W + p);
            res.status = ST_OK;
            found      = 1'b1;
          end
        end
      end
    end else if (int'(blk) >= MAP_BLOCKS) begin
      res.status = ST_RANGE;
    end else begin
      usage_map[blk / WORD_W][WORD_W-1-(blk % WORD_W)] = 1'b0;
    end
    return res;
  endfunction

  task automatic send_beat(input logic mode, input logic [BLK_W-1:0] blk);
    grant_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0000, blk};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = predict_grant(mode, blk);
    pending_results.push_back(res);
    if (mode == MODE_ALLOC && res.status == ST_OK) held_blocks.push_back(res.grant);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Reserved block, freeing used and already free blocks, and the ignored block field.
  task automatic test_directed();
    send_beat(MODE_ALLOC, 12'h000);
    send_beat(MODE_ALLOC, 12'hfff);
    send_beat(MODE_ALLOC, 12'haaa);
    send_beat(MODE_FREE,  12'h002);
    send_beat(MODE_ALLOC, 12'h555);
    send_beat(MODE_FREE,  12'h000);
    send_beat(MODE_ALLOC, 12'h000);
    send_beat(MODE_FREE,  12'hfff);
    send_beat(MODE_FREE,  12'h555);
    send_beat(MODE_FREE,  12'haaa);
    send_beat(MODE_FREE,  12'h003);
    send_beat(MODE_FREE,  12'h003);
    send_beat(MODE_ALLOC, 12'h7ff);
    send_beat(MODE_FREE,  12'h800);
    send_beat(MODE_ALLOC, 12'h800);
    send_beat(MODE_FREE,  12'h001);
    send_beat(MODE_FREE,  12'h01f);
    send_beat(MODE_FREE,  12'h020);
    send_beat(MODE_ALLOC, 12'h001);
    send_beat(MODE_ALLOC, 12'h0f0);
    wait_drained();
  endtask

  // Mostly allocations and frees of held blocks, so the map churns; some frees hit
  // arbitrary block numbers. Halfway through, the sender waits for every result.
  task automatic test_random(input int unsigned n_items);
    int unsigned      pick;
    int unsigned      alloc_cut;
    int unsigned      idx;
    logic [BLK_W-1:0] blk;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drained();
      pick      = $urandom_range(99);
      alloc_cut = (held_blocks.size() > 200) ? 35 : 50;
      if (pick < alloc_cut) begin
        send_beat(MODE_ALLOC, BLK_W'($urandom));
      end else if (pick < 90 && held_blocks.size() > 0) begin
        idx = $urandom_range(held_blocks.size() - 1);
        blk = held_blocks[idx];
        held_blocks.delete(idx);
        send_beat(MODE_FREE, blk);
      end else begin
        send_beat(MODE_FREE, BLK_W'($urandom));
      end
    end
    wait_drained();
  endtask

  always @(posedge clk) begin : result_check
    grant_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: actual grant %0d status %0d",
                 $time, out_tdata[11:0], out_tdata[13:12]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[11:0] !== want.grant) begin
          $display("%0t: granted_block mismatch: expected %0d actual %0d",
                   $time, want.grant, out_tdata[11:0]);
          error_count++;
        end
        if (out_tdata[13:12] !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, out_tdata[13:12]);
          error_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    usage_map    = '{default: '0};
    usage_map[0] = TOP_BIT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_idling(26, 26);
    test_directed();
    set_idling(0, 0);
    test_random(190);
    set_idling(52, 0);
    test_random(190);
    set_idling(0, 52);
    test_random(190);
    set_idling(26, 26);
    test_random(190);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
